FILE: sv/hss_pkg.sv
package hss_pkg;

	// Frame limits and ring geometry.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int RING_DEPTH = 2 * MAX_WIDTH + 3;
	localparam int ADDR_W     = $clog2(RING_DEPTH);
	localparam int MIN_SIZE   = 3;

	// Field and register widths.
	localparam int SIZE_W     = 11;
	localparam int SCALE_W    = 16;
	localparam int OFFSET_W   = 24;
	localparam int PIXEL_W    = 8;
	localparam int HEIGHT_W   = 26;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int CNT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int AREA_W     = $clog2((MAX_WIDTH - 2) * (MAX_HEIGHT - 2) + 1);
	localparam int SUM_W      = 46;
	localparam int WIN_SUM_W  = HEIGHT_W + 4;

	// Rounded divide by nine: (mag + 4) * ceil(2^33 / 9) >> 33.
	localparam int MAG_W       = WIN_SUM_W - 1;
	localparam int RECIP_W     = 30;
	localparam int RECIP_SHIFT = 33;
	localparam int PROD_W      = MAG_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_NINE = 30'd954437177;

	// Configuration port.
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 24;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_SCALE  = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_OFFSET = 4'd3;

	localparam logic [SIZE_W-1:0]   RST_FRAME_WIDTH   = 11'd1024;
	localparam logic [SIZE_W-1:0]   RST_FRAME_HEIGHT  = 11'd1024;
	localparam logic [SCALE_W-1:0]  RST_HEIGHT_SCALE  = 16'd256;
	localparam logic [OFFSET_W-1:0] RST_HEIGHT_OFFSET = 24'd0;

	typedef logic signed [HEIGHT_W-1:0] height_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CALC,
		S_RD1,
		S_RD2,
		S_RD3,
		S_SUM,
		S_MUL,
		S_OUT,
		S_PUT
	} state_t;

	typedef struct packed {
		logic                     start;
		logic signed [SUM_W-1:0]  dividend;
		logic [AREA_W-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic    busy;
		height_t quotient;
	} div_rsp_t;

endpackage

FILE: sv/hss_pix_if.sv
interface hss_pix_if import hss_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               mode;
	logic [PIXEL_W-1:0] pixel;

	modport source (output valid, output mode, output pixel, input ready);
	modport sink (input valid, input mode, input pixel, output ready);
endinterface

FILE: sv/hss_res_if.sv
interface hss_res_if import hss_pkg::*; ();
	logic    valid;
	logic    ready;
	height_t smoothed_height;
	logic    last;
	height_t average_height;

	modport source (output valid, output smoothed_height, output last, output average_height,
		input ready);
	modport sink (input valid, input smoothed_height, input last, input average_height,
		output ready);
endinterface

FILE: sv/hss_cfg_if.sv
interface hss_cfg_if import hss_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/hss_ram.sv
module hss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/hss_div.sv
module hss_div import hss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int DCNT_W = $clog2(SUM_W);

	logic              busy_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              neg_q;
	logic [AREA_W-1:0] den_q;
	logic [AREA_W-1:0] rem_q;
	logic [SUM_W-1:0]  quo_q;

	logic [AREA_W:0]     trial;
	logic                fits;
	logic [SUM_W-1:0]    mag;
	logic [HEIGHT_W-1:0] quo_low;

	assign trial   = {rem_q, quo_q[SUM_W-1]};
	assign fits    = trial >= {1'b0, den_q};
	assign mag     = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
	assign quo_low = quo_q[HEIGHT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == DCNT_W'(SUM_W - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + DCNT_W'(1);
		end
	end

	// One quotient bit per cycle; the dividend shifts out of quo_q as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[SUM_W-1];
			den_q <= req.divisor;
			rem_q <= '0;
			quo_q <= mag;
		end else if (busy_q) begin
			rem_q <= fits ? AREA_W'(trial - {1'b0, den_q}) : AREA_W'(trial);
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.quotient = neg_q ? -$signed(quo_low) : $signed(quo_low);

endmodule

FILE: sv/heightmap_scale_and_smooth_unit.sv
// A pixel that yields no result is accepted, then scaled and stored in the line store.
// An item that yields a result then goes through three line store reads on one read
// port, one sum, one reciprocal multiply, write-back and the output load.
// The last result of a frame also waits for the bit-serial mean divider.
// One item is in flight at a time: a new pixel is accepted only once the previous is done.
// Reset (arst_n low) clears all counters and handshakes; the line store is not cleared.
module heightmap_scale_and_smooth_unit import hss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	hss_pix_if.sink   pixels,
	hss_res_if.source results,
	hss_cfg_if.sink   cfg
);

	function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
		logic [SIZE_W-1:0] hi);
		logic [SIZE_W-1:0] r;
		if (v < SIZE_W'(MIN_SIZE)) begin
			r = SIZE_W'(MIN_SIZE);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] next_slot(logic [ADDR_W-1:0] a);
		return (a == ADDR_W'(RING_DEPTH - 1)) ? '0 : a + ADDR_W'(1);
	endfunction

	function automatic logic [ADDR_W-1:0] wrap_slot(logic [ADDR_W:0] a);
		return (a >= (ADDR_W+1)'(RING_DEPTH)) ? ADDR_W'(a - (ADDR_W+1)'(RING_DEPTH))
			: ADDR_W'(a);
	endfunction

	state_t state_q, state_d;

	// Configuration registers.
	logic [SIZE_W-1:0]          frame_width_q;
	logic [SIZE_W-1:0]          frame_height_q;
	logic [SCALE_W-1:0]         height_scale_q;
	logic signed [OFFSET_W-1:0] height_offset_q;
	logic [CNT_W-1:0]           total_q;
	logic [AREA_W-1:0]          area_q;

	// Frame position state.
	logic [CNT_W-1:0]        rcv_q;
	logic [CNT_W-1:0]        emitted_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic signed [SUM_W-1:0] isum_q;
	logic [ADDR_W-1:0]       wslot_q;
	logic [ADDR_W-1:0]       eslot_q;

	// Item and working registers.
	logic                          mode_q;
	logic [PIXEL_W-1:0]            pixel_q;
	height_t                       l_top_q, l_mid_q, l_bot_q;
	height_t                       c_top_q, c_mid_q, c_bot_q;
	height_t                       r_top_q, r_mid_q, r_bot_q;
	logic signed [WIN_SUM_W-1:0]   sum_a_q, sum_b_q;
	logic [MAG_W-1:0]              mag_q;
	logic                          neg_q;
	logic [PROD_W-1:0]             prod_q;
	height_t                       value_q;
	logic                          last_q;

	// Output register.
	logic    out_valid_q;
	height_t out_height_q;
	logic    out_last_q;
	height_t out_avg_q;

	// Combinational signals.
	logic [SIZE_W-1:0]          w_c, h_c;
	logic [2*SIZE_W-1:0]        total_full, area_full;
	logic [SCALE_W+PIXEL_W-1:0] mul_c;
	height_t                    hv_c;
	logic                       restart;
	logic [CNT_W-1:0]           rcv_e, emitted_e, rcv_n;
	logic [ADDR_W-1:0]          wslot_e, eslot_e, es_base, e1;
	logic                       accepted, emit_c;
	logic [ADDR_W-1:0]          top_addr, bot_addr;
	logic                       interior;
	logic signed [WIN_SUM_W-1:0] win_sum, win_abs;
	logic [HEIGHT_W-1:0]        quo_c;
	height_t                    smooth_c, value_c;
	logic signed [SUM_W-1:0]    isum_n;
	logic                       last_c;
	logic [SIZE_W-1:0]          col_inc;
	logic                       out_free, put_fire;

	logic                ram_we, ram_re;
	logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
	height_t             ram_wdata;
	logic [HEIGHT_W-1:0] ram_rdata;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign w_c        = clamp_size(frame_width_q, SIZE_W'(MAX_WIDTH));
	assign h_c        = clamp_size(frame_height_q, SIZE_W'(MAX_HEIGHT));
	assign total_full = (2*SIZE_W)'(w_c) * (2*SIZE_W)'(h_c);
	assign area_full  = (2*SIZE_W)'(w_c - SIZE_W'(2)) * (2*SIZE_W)'(h_c - SIZE_W'(2));

	assign mul_c = (SCALE_W+PIXEL_W)'(height_scale_q) * (SCALE_W+PIXEL_W)'(pixel_q);
	assign hv_c  = $signed(HEIGHT_W'(mul_c))
		+ $signed({{(HEIGHT_W-OFFSET_W){height_offset_q[OFFSET_W-1]}}, height_offset_q});

	// A finished frame restarts when the next item arrives.
	assign restart   = emitted_q >= total_q;
	assign rcv_e     = restart ? '0 : rcv_q;
	assign emitted_e = restart ? '0 : emitted_q;
	assign wslot_e   = restart ? '0 : wslot_q;
	assign eslot_e   = restart ? '0 : eslot_q;
	assign accepted  = !mode_q && (rcv_e < total_q);
	assign rcv_n     = rcv_e + CNT_W'(accepted);
	assign emit_c    = mode_q ? (rcv_n >= total_q)
		: (accepted && ((CNT_W+1)'(rcv_n) >= (CNT_W+1)'(emitted_e) + (CNT_W+1)'(w_c)
			+ (CNT_W+1)'(2)));

	// The window slides one column per result; the new column sits one slot past the
	// emitted pixel, one row above, level and below.
	assign es_base  = (state_q == S_CALC) ? eslot_e : eslot_q;
	assign e1       = next_slot(es_base);
	assign top_addr = wrap_slot((ADDR_W+1)'(e1) + (ADDR_W+1)'(RING_DEPTH) - (ADDR_W+1)'(w_c));
	assign bot_addr = wrap_slot((ADDR_W+1)'(e1) + (ADDR_W+1)'(w_c));

	assign interior = (row_q != '0) && (SIZE_W'(row_q) < h_c - SIZE_W'(1))
		&& (col_q != '0) && (SIZE_W'(col_q) < w_c - SIZE_W'(1));

	assign win_sum  = sum_a_q + sum_b_q;
	assign win_abs  = win_sum[WIN_SUM_W-1] ? -win_sum : win_sum;
	assign quo_c    = prod_q[RECIP_SHIFT +: HEIGHT_W];
	assign smooth_c = neg_q ? -$signed(quo_c) : $signed(quo_c);
	assign value_c  = interior ? smooth_c : c_mid_q;
	assign isum_n   = interior ? isum_q + SUM_W'(smooth_c) : isum_q;
	assign last_c   = (emitted_q + CNT_W'(1)) == total_q;
	assign col_inc  = SIZE_W'(col_q) + SIZE_W'(1);

	assign out_free = !out_valid_q || results.ready;

	assign div_req.dividend = isum_n;
	assign div_req.divisor  = area_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (pixels.valid) begin
					state_d = S_CALC;
				end
			end
			S_CALC: state_d = emit_c ? S_RD1 : S_IDLE;
			S_RD1:  state_d = S_RD2;
			S_RD2:  state_d = S_RD3;
			S_RD3:  state_d = S_SUM;
			S_SUM:  state_d = S_MUL;
			S_MUL:  state_d = S_OUT;
			S_OUT:  state_d = S_PUT;
			S_PUT: begin
				if (put_fire) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		pixels.ready  = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = wslot_e;
		ram_wdata     = hv_c;
		ram_re        = 1'b0;
		ram_raddr     = bot_addr;
		div_req.start = 1'b0;
		put_fire      = 1'b0;
		case (state_q)
			S_IDLE: pixels.ready = 1'b1;
			S_CALC: begin
				ram_we    = accepted;
				ram_re    = emit_c;
				ram_raddr = top_addr;
			end
			S_RD1: begin
				ram_re    = 1'b1;
				ram_raddr = e1;
			end
			S_RD2: begin
				ram_re    = 1'b1;
				ram_raddr = bot_addr;
			end
			S_OUT: begin
				ram_we        = interior;
				ram_waddr     = eslot_q;
				ram_wdata     = smooth_c;
				div_req.start = last_c;
			end
			S_PUT: put_fire = out_free && (!last_q || !div_rsp.busy);
			default: ;
		endcase
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			frame_width_q   <= RST_FRAME_WIDTH;
			frame_height_q  <= RST_FRAME_HEIGHT;
			height_scale_q  <= RST_HEIGHT_SCALE;
			height_offset_q <= RST_HEIGHT_OFFSET;
			total_q         <= CNT_W'(MAX_WIDTH * MAX_HEIGHT);
			area_q          <= AREA_W'((MAX_WIDTH - 2) * (MAX_HEIGHT - 2));
			rcv_q           <= '0;
			emitted_q       <= '0;
			col_q           <= '0;
			row_q           <= '0;
			isum_q          <= '0;
			wslot_q         <= '0;
			eslot_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			total_q <= CNT_W'(total_full);
			area_q  <= AREA_W'(area_full);

			if (cfg.valid) begin
				case (cfg.index)
					REG_FRAME_WIDTH:   frame_width_q   <= cfg.data[SIZE_W-1:0];
					REG_FRAME_HEIGHT:  frame_height_q  <= cfg.data[SIZE_W-1:0];
					REG_HEIGHT_SCALE:  height_scale_q  <= cfg.data[SCALE_W-1:0];
					REG_HEIGHT_OFFSET: height_offset_q <= $signed(cfg.data[OFFSET_W-1:0]);
					default: ;
				endcase
			end

			if (state_q == S_CALC) begin
				rcv_q     <= rcv_n;
				emitted_q <= emitted_e;
				wslot_q   <= accepted ? next_slot(wslot_e) : wslot_e;
				eslot_q   <= eslot_e;
				if (restart) begin
					col_q  <= '0;
					row_q  <= '0;
					isum_q <= '0;
				end
			end

			if (state_q == S_OUT) begin
				if (last_c) begin
					rcv_q     <= '0;
					emitted_q <= '0;
					col_q     <= '0;
					row_q     <= '0;
					isum_q    <= '0;
					wslot_q   <= '0;
					eslot_q   <= '0;
				end else begin
					emitted_q <= emitted_q + CNT_W'(1);
					eslot_q   <= next_slot(eslot_q);
					isum_q    <= isum_n;
					if (col_inc >= w_c) begin
						col_q <= '0;
						row_q <= row_q + ROW_W'(1);
					end else begin
						col_q <= COL_W'(col_inc);
					end
				end
			end

			if (put_fire) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pixels.valid && pixels.ready) begin
			mode_q  <= pixels.mode;
			pixel_q <= pixels.pixel;
		end

		// The first pixel of a frame is the centre of the first window.
		if (state_q == S_CALC && accepted && rcv_e == '0) begin
			c_mid_q <= hv_c;
		end

		case (state_q)
			S_RD1: r_top_q <= $signed(ram_rdata);
			S_RD2: r_mid_q <= $signed(ram_rdata);
			S_RD3: begin
				r_bot_q <= $signed(ram_rdata);
				sum_a_q <= WIN_SUM_W'(l_top_q) + WIN_SUM_W'(l_mid_q) + WIN_SUM_W'(l_bot_q)
					+ WIN_SUM_W'(c_top_q) + WIN_SUM_W'(c_mid_q) + WIN_SUM_W'(c_bot_q);
				sum_b_q <= WIN_SUM_W'(r_top_q) + WIN_SUM_W'(r_mid_q)
					+ WIN_SUM_W'($signed(ram_rdata));
			end
			S_SUM: begin
				neg_q <= win_sum[WIN_SUM_W-1];
				mag_q <= MAG_W'(win_abs) + MAG_W'(4);
			end
			S_MUL: prod_q <= PROD_W'(mag_q) * PROD_W'(RECIP_NINE);
			S_OUT: begin
				value_q <= value_c;
				last_q  <= last_c;
				// The centre moves left carrying its smoothed value.
				l_top_q <= c_top_q;
				l_mid_q <= value_c;
				l_bot_q <= c_bot_q;
				c_top_q <= r_top_q;
				c_mid_q <= r_mid_q;
				c_bot_q <= r_bot_q;
			end
			default: ;
		endcase

		if (put_fire) begin
			out_height_q <= value_q;
			out_last_q   <= last_q;
			out_avg_q    <= last_q ? div_rsp.quotient : '0;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.smoothed_height = out_height_q;
	assign results.last            = out_last_q;
	assign results.average_height  = out_avg_q;

	hss_ram #(
		.WIDTH (HEIGHT_W),
		.DEPTH (RING_DEPTH)
	) u_line_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	hss_div u_mean_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

FILE: sv/hss_checker.sv
module hss_checker import hss_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input logic    out_last,
	input height_t out_height,
	input height_t out_avg
);

	// A stalled result beat holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_height) && $stable(out_last)
			&& $stable(out_avg))
		else $error("result beat changed while stalled");

	// One item at a time: ready drops right after an accepted beat.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	// The mean is only reported on the last pixel of a frame.
	a_avg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> out_avg == '0)
		else $error("average height nonzero on a non-last beat");

	// A new result is loaded only while an item is being worked on.
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the block was idle");

endmodule

bind heightmap_scale_and_smooth_unit hss_checker u_hss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pixels.valid),
	.in_ready   (pixels.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_last   (results.last),
	.out_height (results.smoothed_height),
	.out_avg    (results.average_height)
);
